@@ rtl/irm_pkg.sv @@
// Package for the interval range map table: field widths, payload and control types.
package irm_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 8;
    localparam int ENTRIES_DEF = 64;

    typedef enum logic {
        REQ_ASSIGN = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_DONE
    } irm_state_t;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] range_start;
        logic signed [KEY_W-1:0] range_stop;
        logic        [VAL_W-1:0] new_value;
        logic signed [KEY_W-1:0] query_key;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0] lookup_value;
        logic             table_full;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic   shift;
        logic   write;
        entry_t wdata;
    } cell_ctl_t;

endpackage

@@ rtl/irm_cell.sv @@
// One breakpoint cell of the shifting table chain.
module irm_cell
    import irm_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int PW       = 7
)
(
    input  logic            clk,
    input  cell_ctl_t       ctl,
    input  logic [PW-1:0]   pos,
    input  entry_t          neighbour,
    output entry_t          q
);

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        priority if (ctl.write && pos == PW'(CELL_IDX))
        begin
            data_next = ctl.wdata;
        end
        else if (ctl.shift)
        begin
            data_next = neighbour;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

@@ rtl/irm_ctrl.sv @@
// Sequencer: walks the chain head for lookups, the fit check and the table rebuild.
module irm_ctrl
    import irm_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int PW      = $clog2(ENTRIES + 2)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  req_t            req,
    input  logic            cfg_we,
    input  logic [VAL_W-1:0] cfg_data,
    input  entry_t          head,
    output logic            busy,
    output logic            done,
    output rsp_t            result,
    output cell_ctl_t       ctl,
    output logic [PW-1:0]   pos
);

    localparam int CW = $clog2(ENTRIES + 3);

    irm_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [VAL_W-1:0] dflt_reg;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] k_reg, k_next;
    logic ins_b_reg, ins_b_next;
    logic ins_e_reg, ins_e_next;
    logic [VAL_W-1:0] ev_reg, ev_next;
    logic [VAL_W-1:0] prev_reg, prev_next;
    logic lookup_reg, lookup_next;
    logic signed [KEY_W-1:0] b_reg, b_next;
    logic signed [KEY_W-1:0] e_reg, e_next;
    logic [VAL_W-1:0] v_reg, v_next;
    rsp_t res_reg, res_next;

    logic accept;
    logic hv;
    logic pop;
    logic have;
    logic emit;
    logic fin;
    entry_t elem;
    logic [CW-1:0] r_step;
    logic [CW-1:0] k_step;
    logic [VAL_W-1:0] ev_step;
    logic [VAL_W-1:0] prev_step;
    logic ins_b_step;
    logic ins_e_step;

    assign accept = start && (state_reg == S_IDLE);
    assign hv     = (r_reg != '0);

    // one scratch element per cycle
    always_comb
    begin
        pop        = 1'b0;
        have       = 1'b0;
        fin        = 1'b0;
        elem       = head;
        ev_step    = ev_reg;
        ins_b_step = ins_b_reg;
        ins_e_step = ins_e_reg;
        priority if (!ins_b_reg)
        begin
            if (hv && head.key < b_reg)
            begin
                pop     = 1'b1;
                have    = 1'b1;
                ev_step = head.value;
            end
            else
            begin
                have       = 1'b1;
                elem.key   = b_reg;
                elem.value = v_reg;
                ins_b_step = 1'b1;
            end
        end
        else if (!ins_e_reg)
        begin
            if (hv && head.key <= e_reg)
            begin
                pop     = 1'b1;
                ev_step = head.value;
            end
            else
            begin
                have       = 1'b1;
                elem.key   = e_reg;
                elem.value = ev_reg;
                ins_e_step = 1'b1;
            end
        end
        else if (hv)
        begin
            pop  = 1'b1;
            have = 1'b1;
        end
        else
        begin
            fin = 1'b1;
        end
        emit      = have && (elem.value != prev_reg);
        k_step    = k_reg + CW'(emit);
        r_step    = r_reg - CW'(pop);
        prev_step = emit ? elem.value : prev_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == REQ_ASSIGN && !(req.range_start < req.range_stop))
                        state_next = S_DONE;
                    else
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (fin)
                begin
                    if (lookup_reg || k_reg > CW'(ENTRIES))
                        state_next = S_DONE;
                    else
                        state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (fin)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and cell control
    always_comb
    begin
        count_next  = count_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        ins_b_next  = ins_b_reg;
        ins_e_next  = ins_e_reg;
        ev_next     = ev_reg;
        prev_next   = prev_reg;
        lookup_next = lookup_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        v_next      = v_reg;
        res_next    = res_reg;
        ctl         = '0;
        pos         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lookup_next = (req.req_type == REQ_LOOKUP);
                    b_next      = lookup_next ? req.query_key : req.range_start;
                    e_next      = lookup_next ? req.query_key : req.range_stop;
                    v_next      = req.new_value;
                    r_next      = count_reg;
                    k_next      = '0;
                    ins_b_next  = 1'b0;
                    ins_e_next  = 1'b0;
                    ev_next     = dflt_reg;
                    prev_next   = dflt_reg;
                    res_next    = '0;
                end
            end
            S_CHECK:
            begin
                // rotate the old table once, head re-enters at the tail
                ctl.shift = pop;
                ctl.write = pop;
                ctl.wdata = head;
                pos       = PW'(count_reg - 1'b1);
                r_next     = r_step;
                k_next     = k_step;
                ins_b_next = ins_b_step;
                ins_e_next = ins_e_step;
                ev_next    = ev_step;
                prev_next  = prev_step;
                if (fin)
                begin
                    if (lookup_reg)
                    begin
                        res_next.lookup_value = ev_reg;
                    end
                    else if (k_reg > CW'(ENTRIES))
                    begin
                        res_next.table_full = 1'b1;
                    end
                    else
                    begin
                        r_next     = count_reg;
                        k_next     = '0;
                        ins_b_next = 1'b0;
                        ins_e_next = 1'b0;
                        ev_next    = dflt_reg;
                        prev_next  = dflt_reg;
                    end
                end
            end
            S_WRITE:
            begin
                // new entries are appended behind the unread old ones
                ctl.shift  = pop;
                ctl.write  = emit;
                ctl.wdata  = elem;
                pos        = PW'(r_step + k_reg);
                r_next     = r_step;
                k_next     = k_step;
                ins_b_next = ins_b_step;
                ins_e_next = ins_e_step;
                ev_next    = ev_step;
                prev_next  = prev_step;
                if (fin)
                    count_next = k_reg;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy   = (state_reg != S_IDLE);
        done   = (state_reg == S_DONE);
        result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dflt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                dflt_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        k_reg      <= k_next;
        ins_b_reg  <= ins_b_next;
        ins_e_reg  <= ins_e_next;
        ev_reg     <= ev_next;
        prev_reg   <= prev_next;
        lookup_reg <= lookup_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        v_reg      <= v_next;
        res_reg    <= res_next;
    end

    a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= ENTRIES)
        else $error("entry count beyond table depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (int'(r_reg) + int'(k_reg) <= ENTRIES + 2))
        else $error("rebuild overruns the chain");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (result.lookup_value == '0))
        else $error("full flag with a lookup value");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

@@ rtl/interval_range_map_table.sv @@
// Interval range map table top level: sequencer and chain of breakpoint cells.
// A lookup runs the check pass, then done; a fitting assign runs check, write
// and done; a rejected one ends after check, an empty range goes straight to
// done. The breakpoint chain's head cell is read once per cycle: one pass
// rotates the table to check the fit (or find a lookup value), a second
// rebuilds it. done is high for exactly one cycle with the result and cannot
// be held off; busy stays high until after that cycle. default_value may be
// written any time busy is low.
module interval_range_map_table
    import irm_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             result,
    input  logic             cfg_we,
    input  logic [VAL_W-1:0] cfg_data
);

    localparam int CELLS = ENTRIES + 2;
    localparam int PW    = $clog2(ENTRIES + 2);

    cell_ctl_t     ctl;
    logic [PW-1:0] pos;
    entry_t        cell_q [CELLS];

    irm_ctrl #(
        .ENTRIES (ENTRIES),
        .PW      (PW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .head     (cell_q[0]),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .ctl      (ctl),
        .pos      (pos)
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        entry_t nb;
        if (i == CELLS - 1)
        begin : g_last
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = cell_q[i + 1];
        end
        irm_cell #(
            .CELL_IDX (i),
            .PW       (PW)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .pos       (pos),
            .neighbour (nb),
            .q         (cell_q[i])
        );
    end

endmodule
